FILE: rtl/core/rmma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmma_pkg
// Shared types, widths and helpers for the running min/max and moving
// average block.
// ----------------------------------------------------------------------------
package rmma_pkg;

   localparam int WINDOW_DEFAULT = 5;
   localparam int TEMP_W         = 16;
   localparam int CHARGE_W       = 15;
   localparam int DIV_RADIX_BITS = 4;   // quotient bits per divider cycle

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [CHARGE_W-1:0]      charge;
   } sample_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_min;
      logic signed [TEMP_W-1:0] temp_max;
      logic [CHARGE_W-1:0]      min_charge;
      logic [CHARGE_W-1:0]      max_charge;
      logic signed [TEMP_W-1:0] avg_temperature;
      logic [CHARGE_W-1:0]      avg_charge;
   } result_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;      // take the sample, update window, sums, extremes
      logic div_start;   // load both dividers from the sums
      logic div_step;    // one divider step
      logic out_load;    // capture the result into the output register
   } cmd_type;

   // bits of the held-sample count, 0 to window
   function automatic int count_width(input int window);
      return $clog2(window + 1);
   endfunction

   // divider steps per item; the temperature sum is the widest dividend
   function automatic int div_steps(input int window);
      return (TEMP_W + count_width(window) + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   endfunction

endpackage

FILE: rtl/core/rmma_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmma_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface rmma_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/rmma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmma_ctrl
// Sequencer: accept, divider setup, divider cycles, result hand-off.
// ----------------------------------------------------------------------------
module rmma_ctrl #(
   parameter int WINDOW = rmma_pkg::WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmma_pkg::cmd_type cmd
);
   localparam int DIV_STEPS = rmma_pkg::div_steps(WINDOW);
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign cmd.accept     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.div_start  = (state_ff == ST_START);
   assign cmd.div_step   = (state_ff == ST_DIV);
   assign cmd.out_load   = (state_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a load in the same cycle keeps valid high for the new item
         if (rsp_valid_ff && rsp_ready && !cmd.out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_OUT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/rmma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmma_dp
// Sample window, running sums, extremes, two radix-16 restoring dividers
// sharing the held count as divisor, and the output register.
// ----------------------------------------------------------------------------
module rmma_dp #(
   parameter int WINDOW = rmma_pkg::WINDOW_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmma_pkg::cmd_type    cmd,
   input  rmma_pkg::sample_type req_payload,
   output rmma_pkg::result_type rsp_payload
);
   localparam int TW        = rmma_pkg::TEMP_W;
   localparam int CHW       = rmma_pkg::CHARGE_W;
   localparam int CW        = rmma_pkg::count_width(WINDOW);
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TSW       = TW + CW;
   localparam int CSW       = CHW + CW;
   localparam int RB        = rmma_pkg::DIV_RADIX_BITS;
   localparam int DQ_W      = rmma_pkg::div_steps(WINDOW) * RB;
   localparam int REM_W     = CW + 1;

   logic signed [TW-1:0]  temp_window_ff [WINDOW];
   logic [CHW-1:0]        charge_window_ff [WINDOW];
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CW-1:0]         count_ff, count_in;
   logic signed [TSW-1:0] temp_sum_ff, temp_sum_in;
   logic [CSW-1:0]        charge_sum_ff, charge_sum_in;
   logic signed [TW-1:0]  tmin_ff, tmax_ff, tmin_in, tmax_in;
   logic [CHW-1:0]        cmin_ff, cmax_ff, cmin_in, cmax_in;

   logic [REM_W-1:0]      t_rem_ff, c_rem_ff;
   logic [DQ_W-1:0]       t_quo_ff, c_quo_ff;
   logic                  t_neg_ff;
   rmma_pkg::result_type  rsp_ff;

   logic                  first, full;
   logic signed [TW-1:0]  t_new, t_old;
   logic [CHW-1:0]        c_new, c_old;
   logic [TSW-1:0]        t_mag;
   logic [REM_W+DQ_W-1:0] t_next, c_next;
   logic [DQ_W-1:0]       t_avg;

   // RB restoring steps on a narrow remainder
   function automatic logic [REM_W+DQ_W-1:0] div_digits(
      input logic [REM_W-1:0] rem,
      input logic [DQ_W-1:0]  quo,
      input logic [CW-1:0]    divisor
   );
      logic [REM_W-1:0] r;
      logic [DQ_W-1:0]  q;
      r = rem;
      q = quo;
      for (int k = 0; k < RB; k++) begin
         r = {r[CW-1:0], q[DQ_W-1]};
         q = {q[DQ_W-2:0], 1'b0};
         if (r >= {1'b0, divisor}) begin
            r    = r - {1'b0, divisor};
            q[0] = 1'b1;
         end
      end
      return {r, q};
   endfunction

   // ---- window and extremes update
   assign t_new = req_payload.temperature;
   assign c_new = req_payload.charge;
   assign first = (count_ff == '0);
   assign full  = (count_ff == CW'(WINDOW));
   assign t_old = full ? temp_window_ff[slot_ff] : '0;
   assign c_old = full ? charge_window_ff[slot_ff] : '0;

   assign temp_sum_in   = temp_sum_ff + TSW'(t_new) - TSW'(t_old);
   assign charge_sum_in = charge_sum_ff + {{CW{1'b0}}, c_new} - {{CW{1'b0}}, c_old};
   assign slot_in       = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign count_in      = full ? count_ff : count_ff + 1'b1;

   assign tmin_in = (first || t_new < tmin_ff) ? t_new : tmin_ff;
   assign tmax_in = (first || t_new > tmax_ff) ? t_new : tmax_ff;
   assign cmin_in = (first || c_new < cmin_ff) ? c_new : cmin_ff;
   assign cmax_in = (first || c_new > cmax_ff) ? c_new : cmax_ff;

   // ---- divider
   assign t_mag  = temp_sum_ff[TSW-1] ? TSW'(-temp_sum_ff) : TSW'(temp_sum_ff);
   assign t_next = div_digits(t_rem_ff, t_quo_ff, count_ff);
   assign c_next = div_digits(c_rem_ff, c_quo_ff, count_ff);
   assign t_avg  = t_neg_ff ? DQ_W'(-t_quo_ff) : t_quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         count_ff      <= '0;
         temp_sum_ff   <= '0;
         charge_sum_ff <= '0;
      end else if (cmd.accept) begin
         slot_ff       <= slot_in;
         count_ff      <= count_in;
         temp_sum_ff   <= temp_sum_in;
         charge_sum_ff <= charge_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         temp_window_ff[slot_ff]   <= t_new;
         charge_window_ff[slot_ff] <= c_new;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         cmin_ff <= cmin_in;
         cmax_ff <= cmax_in;
      end
      if (cmd.div_start) begin
         t_rem_ff <= '0;
         c_rem_ff <= '0;
         t_quo_ff <= DQ_W'(t_mag);
         c_quo_ff <= DQ_W'(charge_sum_ff);
         t_neg_ff <= temp_sum_ff[TSW-1];
      end else if (cmd.div_step) begin
         {t_rem_ff, t_quo_ff} <= t_next;
         {c_rem_ff, c_quo_ff} <= c_next;
      end
      if (cmd.out_load) begin
         rsp_ff.temp_min        <= tmin_ff;
         rsp_ff.temp_max        <= tmax_ff;
         rsp_ff.min_charge      <= cmin_ff;
         rsp_ff.max_charge      <= cmax_ff;
         rsp_ff.avg_temperature <= t_avg[TW-1:0];
         rsp_ff.avg_charge      <= c_quo_ff[CHW-1:0];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/running_minmax_moving_average.sv
`timescale 1ns / 1ps
// Sequence: each accepted item passes a setup state, DIV_STEPS divider steps
//   and an output load that waits until the output register is free.
// The input stays closed until that item has been loaded out; the shared-count
//   divider retires four quotient bits per cycle.
// Reset (synchronous, active high) empties the window: count, slot and sums go
//   to zero and the first item after reset sets all four extremes.
// ----------------------------------------------------------------------------
// running_minmax_moving_average
// Running min/max of temperature and charge since reset, plus moving
// averages over the last WINDOW samples.
// ----------------------------------------------------------------------------
module running_minmax_moving_average #(
   parameter int WINDOW = rmma_pkg::WINDOW_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   rmma_stream_if.sink          req_chan,
   rmma_stream_if.source        rsp_chan
);
   // Control: rmma_ctrl walks IDLE -> START -> DIV (DIV_STEPS steps) -> OUT.
   // The input side is open only in IDLE; the output register lets a
   // finished item wait on rsp_chan while the next item is taken in and
   // worked on. OUT holds until that register is free.
   rmma_pkg::cmd_type cmd;
   logic              req_ready;
   logic              rsp_valid;

   rmma_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Datapath: window ring, sums and extremes update on accept; the
   // averages come from two restoring dividers (magnitude for temperature,
   // sign put back after, so the mean truncates toward zero).
   rmma_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

`ifndef NO_ASSERTIONS
   // an accepted item always starts the divider next cycle
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.div_start)
      else $error("accepted item did not start divider");

   // output register never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_chan.ready))
      else $error("result overwritten before taken");

   // input stays closed while the divider runs
   a_closed_in_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.div_start) |-> !req_ready)
      else $error("input open during divide");

   // extremes ordered in every delivered result
   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chan.payload.temp_min <= rsp_chan.payload.temp_max
                     && rsp_chan.payload.min_charge <= rsp_chan.payload.max_charge))
      else $error("minimum above maximum");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for running_minmax_moving_average. It streams battery
// samples over the request channel with random gaps. A scoreboard predicts
// each result from its own copy of the window, sums and extremes. Every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WINDOW     = rmma_pkg::WINDOW_DEFAULT;
   localparam int TEMP_W     = rmma_pkg::TEMP_W;
   localparam int CHARGE_W   = rmma_pkg::CHARGE_W;
   localparam int RANDOM_N   = 1500;
   localparam int MAX_WAIT   = 19;     // longest gap / stall drawn per item
   localparam int DRAIN_MAX  = 5000;   // cycles allowed for the last results
   localparam int TAIL_CYC   = 30;     // idle tail waited after the drain, past the last result

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own window, sums and extremes, and queues one
   // predicted result per accepted sample.
   // -------------------------------------------------------------------------
   class battery_stats_tracker;
      int               temp_ring [WINDOW];
      int               charge_ring [WINDOW];
      int unsigned      slot;
      int unsigned      held;
      int               temp_total;
      int               charge_total;
      logic signed [TEMP_W-1:0] temp_lo, temp_hi;
      logic [CHARGE_W-1:0]      charge_lo, charge_hi;
      rmma_pkg::result_type     pending_stats[$];
      int               failures;

      function new();
         foreach (temp_ring[i]) begin
            temp_ring[i]   = 0;
            charge_ring[i] = 0;
         end
         slot         = 0;
         held         = 0;
         temp_total   = 0;
         charge_total = 0;
         temp_lo      = '0;
         temp_hi      = '0;
         charge_lo    = '0;
         charge_hi    = '0;
         failures     = 0;
      endfunction

      // predict the result of one accepted sample
      function void note_sample(rmma_pkg::sample_type s);
         rmma_pkg::result_type want;
         int         t;
         int         c;
         t = int'(s.temperature);
         c = int'(s.charge);
         // first sample after reset seeds all four extremes
         if (held == 0) begin
            temp_lo   = s.temperature;
            temp_hi   = s.temperature;
            charge_lo = s.charge;
            charge_hi = s.charge;
         end else begin
            if (s.temperature < temp_lo) temp_lo = s.temperature;
            if (s.temperature > temp_hi) temp_hi = s.temperature;
            if (s.charge < charge_lo)    charge_lo = s.charge;
            if (s.charge > charge_hi)    charge_hi = s.charge;
         end
         // full window: oldest sample drops out of the sums first
         if (held >= WINDOW) begin
            temp_total   -= temp_ring[slot];
            charge_total -= charge_ring[slot];
         end else begin
            held++;
         end
         temp_ring[slot]   = t;
         charge_ring[slot] = c;
         temp_total       += t;
         charge_total     += c;
         slot = (slot + 1) % WINDOW;

         want.temp_min        = temp_lo;
         want.temp_max        = temp_hi;
         want.min_charge      = charge_lo;
         want.max_charge      = charge_hi;
         // int division truncates toward zero, as the averages require
         want.avg_temperature = TEMP_W'(temp_total / int'(held));
         want.avg_charge      = CHARGE_W'(charge_total / int'(held));
         pending_stats.insert(pending_stats.size(), want);
      endfunction

      function void flag(string field, longint want, longint got);
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(rmma_pkg::result_type got);
         rmma_pkg::result_type want;
         if (pending_stats.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, actual %p", $time, got);
            return;
         end
         want = pending_stats.pop_front();
         if (got.temp_min !== want.temp_min)
            flag("temp_min", want.temp_min, got.temp_min);
         if (got.temp_max !== want.temp_max)
            flag("temp_max", want.temp_max, got.temp_max);
         if (got.min_charge !== want.min_charge)
            flag("min_charge", want.min_charge, got.min_charge);
         if (got.max_charge !== want.max_charge)
            flag("max_charge", want.max_charge, got.max_charge);
         if (got.avg_temperature !== want.avg_temperature)
            flag("avg_temperature", want.avg_temperature, got.avg_temperature);
         if (got.avg_charge !== want.avg_charge)
            flag("avg_charge", want.avg_charge, got.avg_charge);
      endfunction

      function int outstanding();
         return pending_stats.size();
      endfunction

      // anything still queued at the end never came out of the block
      function void flush_leftovers();
         while (pending_stats.size() != 0) begin
            failures++;
            $display("%0t: missing result, expected %p", $time, pending_stats.pop_front());
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #2 clock = ~clock;

   rmma_stream_if #(.payload_type(rmma_pkg::sample_type)) req_if ();
   rmma_stream_if #(.payload_type(rmma_pkg::result_type)) rsp_if ();

   running_minmax_moving_average #(
      .WINDOW   (WINDOW)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   battery_stats_tracker tracker = new();

   // Idling on each side is switched on and off in stretches, so some runs
   // of items go back to back at full rate.
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   function automatic int draw_wait(bit enabled);
      return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
   endfunction

   function automatic rmma_pkg::sample_type make_sample(int t, int c);
      rmma_pkg::sample_type s;
      s.temperature = TEMP_W'(t);
      s.charge      = CHARGE_W'(c);
      return s;
   endfunction

   // Drive one sample. Called at a falling edge; returns at the falling edge
   // after the item is taken. valid gets one assignment per time step: when
   // there is no gap, a held-high valid simply carries the new payload.
   task automatic send_sample(input rmma_pkg::sample_type s);
      int gap;
      gap = draw_wait(sender_idles);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= s;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_sample(s);
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stall per item, sample at the rising edge
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait(receiver_idles);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         tracker.check_result(rsp_if.payload);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int opening_t [12] = '{-3, -4, 2, -6, 1, 10, -11, 5, 0, -1, 3, 8};
      int opening_c [12] = '{12800, 13000, 12000, 12999, 12345, 12500,
                             12001, 12700, 12650, 12100, 12900, 12222};
      int closing_t [14] = '{32767, -32768, -32768, 32767,
                             -32768, -32768, -32768, -32768, -32768,
                             32767, 32767, 32767, 32767, 32767};
      int closing_c [14] = '{25600, 0, 32767, 32767,
                             0, 0, 0, 0, 0,
                             32767, 32767, 32767, 32767, 32767};
      int guard;
      int shift;
      int limit;
      int c;
      logic signed [TEMP_W-1:0] raw_t;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening: the first sample seeds the extremes, four more fill the
      // window, the rest wrap the ring. Small negative temperatures give
      // negative sums whose means must truncate toward zero (-7/2 -> -3).
      // Values stay moderate because the extremes are sticky since reset.
      foreach (opening_t[i])
         send_sample(make_sample(opening_t[i], opening_c[i]));

      // Random part: the spread of both fields widens over the run so the
      // running extremes keep moving instead of saturating at once.
      for (int k = 0; k < RANDOM_N; k++) begin
         if (k % 100 == 0) begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         raw_t = TEMP_W'($urandom);
         shift = (k < RANDOM_N / 2) ? 12 - (24 * k) / RANDOM_N : 0;
         limit = 200 + (25400 * k) / (RANDOM_N * 3 / 4);
         if (limit > 25600) limit = 25600;
         c = $urandom_range(0, limit);
         // charge above full scale only late, once max charge may saturate
         if (k >= RANDOM_N * 3 / 4 && $urandom_range(0, 7) == 0)
            c = $urandom_range(25601, 32767);
         send_sample(make_sample(int'(raw_t >>> shift), c));
      end

      // Closing: field extremes, then full windows of the most negative and
      // the most positive values to push the sums to their limits.
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      foreach (closing_t[i])
         send_sample(make_sample(closing_t[i], closing_c[i]));
      req_if.valid <= 1'b0;

      guard = 0;
      while (tracker.outstanding() != 0 && guard < DRAIN_MAX) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYC) @(posedge clock);
      tracker.flush_leftovers();
      if (tracker.failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rmma_pkg.sv
rtl/core/rmma_stream_if.sv
rtl/core/rmma_ctrl.sv
rtl/core/rmma_dp.sv
rtl/core/running_minmax_moving_average.sv
tb/tb_top.sv
